@@ hw/rtl/ibfc_pkg.sv @@
// ----------------------------------------------------------------------------
// ibfc_pkg
// Shared constants and controller/datapath handshake types for the iBUS
// frame channel-change parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ibfc_pkg;

   localparam int FRAME_BYTES_DEF = 32;
   localparam int CHANNELS_DEF    = 14;

   localparam int BYTE_W  = 8;
   localparam int VALUE_W = 16;
   localparam int IDX_W   = 4;
   localparam int THR_W   = 16;

   localparam logic [BYTE_W-1:0] HDR0 = 8'h20;
   localparam logic [BYTE_W-1:0] HDR1 = 8'h40;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd5;

   // commands from the controller to the datapath
   typedef struct packed {
      logic store_byte;    // header check and store of a received byte
      logic start_decode;  // frame end byte: rewind position, clear walk state
      logic rd_lo;         // issue read of a channel low byte
      logic rd_hi;         // latch low byte, issue read of the high byte
      logic compare;       // compare channel against previous, update store
      logic emit_step;     // move to the next channel in the emit walk
      logic emit_load;     // load the output register with the current channel
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic frame_end;     // byte position has reached the frame length
      logic scan_done;     // current channel is the final one
      logic mask_empty;    // no changed channels left to emit
      logic cur_changed;   // current channel is marked as changed
      logic out_free;      // output register can take a result this cycle
   } status_type;

endpackage

`default_nettype wire

@@ hw/rtl/ibfc_if.sv @@
// ----------------------------------------------------------------------------
// ibfc_if
// Valid/ready channel interfaces for the received byte stream and for the
// channel change results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ibfc_req_if;
   logic                          valid;
   logic                          ready;
   logic [ibfc_pkg::BYTE_W-1:0]   rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ibfc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ibfc_pkg::IDX_W-1:0]    channel_index;
   logic [ibfc_pkg::VALUE_W-1:0]  channel_value;
   logic                          last_change;

   modport source (output valid, output channel_index, output channel_value,
                   output last_change, input ready);
   modport sink   (input valid, input channel_index, input channel_value,
                   input last_change, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ibfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ibfc_ctrl
// Sequencer for the parser: takes bytes while idle, walks the channels of a
// finished frame to compare them, then walks them again to emit results.
// ----------------------------------------------------------------------------
`default_nettype none

module ibfc_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  ibfc_pkg::status_type  status,
   output ibfc_pkg::cmd_type     cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_RD_LO = 5'b00010,
      ST_RD_HI = 5'b00100,
      ST_CMP   = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (status.frame_end) begin
                  cmd.start_decode = 1'b1;
                  state_in         = ST_RD_LO;
               end else begin
                  cmd.store_byte = 1'b1;
               end
            end
         end
         ST_RD_LO: begin
            cmd.rd_lo = 1'b1;
            state_in  = ST_RD_HI;
         end
         ST_RD_HI: begin
            cmd.rd_hi = 1'b1;
            state_in  = ST_CMP;
         end
         ST_CMP: begin
            cmd.compare = 1'b1;
            state_in    = status.scan_done ? ST_EMIT : ST_RD_LO;
         end
         ST_EMIT: begin
            if (status.mask_empty) begin
               state_in = ST_IDLE;
            end else if (status.cur_changed) begin
               // hold until the output register can take the transaction
               if (status.out_free) begin
                  cmd.emit_load = 1'b1;
                  cmd.emit_step = 1'b1;
               end
            end else begin
               cmd.emit_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/ibfc_dp.sv @@
// ----------------------------------------------------------------------------
// ibfc_dp
// Datapath for the parser: frame byte memory, byte position, previous
// channel values, change mask, threshold register and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ibfc_dp #(
   parameter int FRAME_BYTES = ibfc_pkg::FRAME_BYTES_DEF,
   parameter int CHANNELS    = ibfc_pkg::CHANNELS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  [ibfc_pkg::BYTE_W-1:0]      rx_byte,
   input  wire                              csr_wr_en,
   input  wire  [ibfc_pkg::THR_W-1:0]       csr_wr_data,
   input  ibfc_pkg::cmd_type                cmd,
   output ibfc_pkg::status_type             status,
   input  wire                              rsp_ready,
   output logic                             rsp_valid,
   output logic [ibfc_pkg::IDX_W-1:0]       rsp_channel_index,
   output logic [ibfc_pkg::VALUE_W-1:0]     rsp_channel_value,
   output logic                             rsp_last_change
);

   localparam int ADDR_W = $clog2(FRAME_BYTES);
   localparam int POS_W  = $clog2(FRAME_BYTES + 1);
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SLOT_W = $clog2(2 * CHANNELS + FRAME_BYTES + 2);

   localparam logic [POS_W-1:0]  POS_END  = POS_W'(FRAME_BYTES);
   localparam logic [CH_W-1:0]   LAST_CH  = CH_W'(CHANNELS - 1);
   localparam logic [SLOT_W-1:0] SLOT_END = SLOT_W'(FRAME_BYTES);

   // frame byte memory
   logic [ibfc_pkg::BYTE_W-1:0]  frame_mem_ff [FRAME_BYTES];
   logic [ibfc_pkg::BYTE_W-1:0]  rd_data_ff;
   logic                         rd_in_range_ff;
   logic                         rd_in_range_in;

   logic [POS_W-1:0]             pos_ff;
   logic [POS_W-1:0]             pos_in;
   logic                         hdr_ok;

   logic [CH_W-1:0]              chan_ff;
   logic [CH_W-1:0]              chan_in;
   logic [CHANNELS-1:0]          mask_ff;
   logic [CHANNELS-1:0]          mask_in;
   logic [CHANNELS-1:0]          cur_bit;
   logic [ibfc_pkg::VALUE_W-1:0] prev_ff [CHANNELS];

   logic [ibfc_pkg::BYTE_W-1:0]  lo_ff;
   logic [ibfc_pkg::BYTE_W-1:0]  rd_byte;
   logic [SLOT_W-1:0]            slot;
   logic [ibfc_pkg::VALUE_W-1:0] new_val;
   logic [ibfc_pkg::VALUE_W-1:0] old_val;
   logic [ibfc_pkg::VALUE_W-1:0] diff;
   logic                         changed;

   logic [ibfc_pkg::THR_W-1:0]   thr_ff;

   logic                         out_valid_ff;
   logic [ibfc_pkg::IDX_W-1:0]   out_idx_ff;
   logic [ibfc_pkg::VALUE_W-1:0] out_val_ff;
   logic                         out_last_ff;
   logic [CH_W+ibfc_pkg::IDX_W-1:0] chan_ext;

   // byte slot of the channel being read: 2 + 2*chan, plus one for the high byte
   assign slot = (SLOT_W'(chan_ff) << 1) + SLOT_W'(2) + SLOT_W'(cmd.rd_hi);
   assign rd_in_range_in = (slot < SLOT_END);
   assign rd_byte = rd_in_range_ff ? rd_data_ff : '0;

   assign hdr_ok = !((pos_ff == POS_W'(0) && rx_byte != ibfc_pkg::HDR0) ||
                     (pos_ff == POS_W'(1) && rx_byte != ibfc_pkg::HDR1));

   always_ff @(posedge clock) begin
      if (cmd.store_byte && hdr_ok) begin
         frame_mem_ff[pos_ff[ADDR_W-1:0]] <= rx_byte;
      end
      if (cmd.rd_lo || cmd.rd_hi) begin
         rd_data_ff     <= frame_mem_ff[slot[ADDR_W-1:0]];
         rd_in_range_ff <= rd_in_range_in;
      end
   end

   assign new_val = {rd_byte, lo_ff};
   assign old_val = prev_ff[chan_ff];
   assign diff    = (new_val >= old_val) ? (new_val - old_val) : (old_val - new_val);
   assign changed = (diff > thr_ff);
   assign cur_bit = CHANNELS'(1) << chan_ff;

   always_comb begin
      pos_in = pos_ff;
      if (cmd.store_byte) begin
         pos_in = hdr_ok ? (pos_ff + POS_W'(1)) : '0;
      end else if (cmd.start_decode) begin
         pos_in = '0;
      end
   end

   always_comb begin
      chan_in = chan_ff;
      mask_in = mask_ff;
      if (cmd.start_decode) begin
         chan_in = '0;
         mask_in = '0;
      end else if (cmd.compare) begin
         chan_in = (chan_ff == LAST_CH) ? '0 : (chan_ff + CH_W'(1));
         mask_in = changed ? (mask_ff | cur_bit) : mask_ff;
      end else if (cmd.emit_step) begin
         chan_in = chan_ff + CH_W'(1);
         if (cmd.emit_load) begin
            mask_in = mask_ff & ~cur_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         chan_ff <= '0;
         mask_ff <= '0;
         thr_ff  <= ibfc_pkg::THRESHOLD_RESET;
         for (int i = 0; i < CHANNELS; i++) begin
            prev_ff[i] <= '0;
         end
      end else begin
         pos_ff  <= pos_in;
         chan_ff <= chan_in;
         mask_ff <= mask_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         if (cmd.compare) begin
            prev_ff[chan_ff] <= new_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_hi) begin
         lo_ff <= rd_byte;
      end
   end

   // output register
   assign chan_ext = {{ibfc_pkg::IDX_W{1'b0}}, chan_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         out_idx_ff  <= chan_ext[ibfc_pkg::IDX_W-1:0];
         out_val_ff  <= old_val;
         out_last_ff <= ((mask_ff & ~cur_bit) == '0);
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_channel_index = out_idx_ff;
   assign rsp_channel_value = out_val_ff;
   assign rsp_last_change   = out_last_ff;

   assign status.frame_end   = (pos_ff == POS_END);
   assign status.scan_done   = (chan_ff == LAST_CH);
   assign status.mask_empty  = (mask_ff == '0);
   assign status.cur_changed = mask_ff[chan_ff];
   assign status.out_free    = !out_valid_ff || rsp_ready;

endmodule

`default_nettype wire

@@ hw/rtl/ibfc_frame_channel_change_parser_top.sv @@
// ----------------------------------------------------------------------------
// ibus_frame_channel_change_parser_top
// Hunts iBUS servo frames in a byte stream and reports channels whose value
// moved by more than a programmable threshold.
// ----------------------------------------------------------------------------
// Usage: each received byte is one input transaction. Ordinary bytes are
// taken in one cycle each. A frame opens with 0x20, 0x40; the byte that
// arrives after FRAME_BYTES stored bytes closes the frame and is discarded,
// and the block then compares the channels in turn (a read of the low byte,
// a read of the high byte and a compare, over the single read port of the
// frame memory) and then walks the change mask, holding while the result
// channel stalls and the output register is full. New bytes are taken
// again only after that walk; results still waiting in the output register do
// not hold off the next byte. The threshold defaults to 5 and is written
// through csr_wr_en/csr_wr_data while the block is idle. The previous-value
// store is all zero after reset; the checksum is not checked.
// ----------------------------------------------------------------------------
`default_nettype none

module ibus_frame_channel_change_parser_top #(
   parameter int FRAME_BYTES = ibfc_pkg::FRAME_BYTES_DEF,
   parameter int CHANNELS    = ibfc_pkg::CHANNELS_DEF
) (
   input  wire                         clock,
   input  wire                         reset,
   ibfc_req_if.sink                    req_bus,
   ibfc_rsp_if.source                  rsp_bus,
   input  wire                         csr_wr_en,
   input  wire [ibfc_pkg::THR_W-1:0]   csr_wr_data
);

   ibfc_pkg::cmd_type    cmd;
   ibfc_pkg::status_type status;

   ibfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ibfc_dp #(
      .FRAME_BYTES (FRAME_BYTES),
      .CHANNELS    (CHANNELS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .rx_byte           (req_bus.rx_byte),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_channel_index (rsp_bus.channel_index),
      .rsp_channel_value (rsp_bus.channel_value),
      .rsp_last_change   (rsp_bus.last_change)
   );

endmodule

`default_nettype wire

@@ tb/ibus_frame_channel_change_parser_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ibus_frame_channel_change_parser_top_tb
// Feeds byte streams of iBUS servo frames, broken headers and line noise into
// the parser and checks every reported channel change against a predicted
// copy of the frame store and previous channel values, over several change
// thresholds and with random idle cycles on both channels.
// ----------------------------------------------------------------------------

module ibus_frame_channel_change_parser_top_tb;

   localparam int FRAME_BYTES   = ibfc_pkg::FRAME_BYTES_DEF;
   localparam int CHANNELS      = ibfc_pkg::CHANNELS_DEF;
   localparam int BYTE_W        = ibfc_pkg::BYTE_W;
   localparam int VALUE_W       = ibfc_pkg::VALUE_W;
   localparam int IDX_W         = ibfc_pkg::IDX_W;
   localparam int THR_W         = ibfc_pkg::THR_W;
   localparam int SETTLE_CYCLES = 120;
   localparam int PHASE_ITEMS   = 50;

   typedef struct packed {
      logic [IDX_W-1:0]   ch_index;
      logic [VALUE_W-1:0] ch_value;
      logic               last_flag;
   } channel_change_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en = 1'b0;
   logic [THR_W-1:0] csr_wr_data = '0;

   ibfc_req_if req_bus ();
   ibfc_rsp_if rsp_bus ();

   ibus_frame_channel_change_parser_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // stimulus and idle control
   logic [BYTE_W-1:0]  rx_byte_queue [$];
   int                 bytes_queued;
   int                 send_idle_pct;
   int                 recv_stall_pct;
   logic [VALUE_W-1:0] planned_values [CHANNELS];

   // predicted parser state
   logic [BYTE_W-1:0]  frame_store [FRAME_BYTES];
   int unsigned        hunt_pos;
   logic [VALUE_W-1:0] seen_values [CHANNELS];
   logic [THR_W-1:0]   threshold_model;
   channel_change_type expected_changes [$];
   int                 mismatch_count;

   task automatic decode_rx_byte(input logic [BYTE_W-1:0] b);
      logic [VALUE_W-1:0] fresh [CHANNELS];
      logic               hit [CHANNELS];
      logic [VALUE_W-1:0] diff;
      logic [BYTE_W-1:0]  lo;
      logic [BYTE_W-1:0]  hi;
      int                 last_hit;
      if (hunt_pos == 0 && b != ibfc_pkg::HDR0) begin
         hunt_pos = 0;
      end else if (hunt_pos == 1 && b != ibfc_pkg::HDR1) begin
         hunt_pos = 0;
      end else if (hunt_pos >= FRAME_BYTES) begin
         // closing byte is dropped, the stored frame is decoded
         hunt_pos = 0;
         last_hit = -1;
         for (int i = 0; i < CHANNELS; i++) begin
            lo = (2 + 2 * i < FRAME_BYTES) ? frame_store[2 + 2 * i] : 8'h00;
            hi = (3 + 2 * i < FRAME_BYTES) ? frame_store[3 + 2 * i] : 8'h00;
            fresh[i] = {hi, lo};
            diff = (fresh[i] >= seen_values[i]) ? fresh[i] - seen_values[i]
                                                : seen_values[i] - fresh[i];
            hit[i] = (diff > threshold_model);
            if (hit[i]) last_hit = i;
            seen_values[i] = fresh[i];
         end
         for (int i = 0; i < CHANNELS; i++) begin
            if (hit[i]) begin
               expected_changes.push_back(
                  channel_change_type'{IDX_W'(i), fresh[i], i == last_hit});
            end
         end
      end else begin
         frame_store[hunt_pos] = b;
         hunt_pos++;
      end
   endtask

   task automatic put_byte(input logic [BYTE_W-1:0] b);
      rx_byte_queue.push_back(b);
      bytes_queued++;
   endtask

   task automatic queue_frame(input logic [VALUE_W-1:0] vals [CHANNELS]);
      put_byte(ibfc_pkg::HDR0);
      put_byte(ibfc_pkg::HDR1);
      for (int i = 0; i < CHANNELS; i++) begin
         put_byte(vals[i][7:0]);
         put_byte(vals[i][15:8]);
         planned_values[i] = vals[i];
      end
      // checksum slots and the closing byte carry random content
      for (int p = 2 + 2 * CHANNELS; p <= FRAME_BYTES; p++) begin
         put_byte(8'($urandom));
      end
   endtask

   task automatic queue_random_frame();
      logic [VALUE_W-1:0] vals [CHANNELS];
      int                 spread;
      int                 delta;
      spread = int'(threshold_model);
      for (int i = 0; i < CHANNELS; i++) begin
         case ($urandom_range(0, 9))
            0: vals[i] = 16'h0000;
            1: vals[i] = 16'hFFFF;
            2, 3: vals[i] = 16'($urandom);
            4: vals[i] = planned_values[i];
            default: begin
               // land near the threshold on either side
               delta = int'($urandom_range(0, 2 * spread + 4)) - (spread + 2);
               vals[i] = 16'(int'(planned_values[i]) + delta);
            end
         endcase
      end
      queue_frame(vals);
   endtask

   task automatic queue_noise();
      logic [BYTE_W-1:0] b;
      case ($urandom_range(0, 2))
         0: put_byte(8'($urandom));
         1: begin
            b = 8'($urandom);
            if (b == ibfc_pkg::HDR1) b = 8'h41;
            put_byte(ibfc_pkg::HDR0);
            put_byte(b);
         end
         default: put_byte(ibfc_pkg::HDR1);
      endcase
      // a byte that matches no header brings the hunt back to the start
      put_byte(8'h00);
   endtask

   task automatic wait_idle();
      while (rx_byte_queue.size() != 0 || req_bus.valid ||
             expected_changes.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] t);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= t;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      threshold_model = t;
   endtask

   // byte driver, also feeds the predictor on each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) decode_rx_byte(req_bus.rx_byte);
         if (!req_bus.valid || req_bus.ready) begin
            if (rx_byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_bus.valid   <= 1'b1;
               req_bus.rx_byte <= rx_byte_queue.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : result_monitor
      channel_change_type got;
      channel_change_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.channel_index, rsp_bus.channel_value, rsp_bus.last_change};
            if (expected_changes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected change ch %0d value %h last %b", $realtime,
                           got.ch_index, got.ch_value, got.last_flag);
            end else begin
               want = expected_changes.pop_front();
               if (got.ch_index !== want.ch_index || got.ch_value !== want.ch_value ||
                   got.last_flag !== want.last_flag) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: expected ch %0d value %h last %b,",
                               " got ch %0d value %h last %b"},
                              $realtime, want.ch_index, want.ch_value, want.last_flag,
                              got.ch_index, got.ch_value, got.last_flag);
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      logic [VALUE_W-1:0] directed_vals [CHANNELS];
      logic [THR_W-1:0]   phase_thr [4];
      int                 phase_send [4];
      int                 phase_recv [4];
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = '0;
      rsp_bus.ready   = 1'b0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      bytes_queued    = 0;
      mismatch_count  = 0;
      hunt_pos        = 0;
      threshold_model = ibfc_pkg::THRESHOLD_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
         seen_values[i]    = '0;
         planned_values[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // broken headers: wrong first byte, wrong second byte, repeated 0x20
      put_byte(8'h00);
      put_byte(8'hFF);
      put_byte(ibfc_pkg::HDR1);
      put_byte(ibfc_pkg::HDR0);
      put_byte(8'h00);
      put_byte(ibfc_pkg::HDR0);
      put_byte(ibfc_pkg::HDR0);
      // full-scale values and both sides of the reset threshold
      directed_vals = '{16'hFFFF, 16'h0000, 16'd5, 16'd6, 16'h0100, 16'h00FF, 16'h8000,
                        16'h7FFF, 16'h0001, 16'hFFFA, 16'h1234, 16'h0000, 16'd4, 16'hABCD};
      queue_frame(directed_vals);
      wait_idle();

      phase_thr  = '{16'd0, 16'hFFFF, 16'($urandom_range(1, 2000)),
                     16'($urandom_range(100, 600))};
      phase_send = '{0, 81, 24, 0};
      phase_recv = '{81, 0, 24, 0};
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = phase_send[ph];
         recv_stall_pct = phase_recv[ph];
         write_threshold(phase_thr[ph]);
         bytes_queued = 0;
         while (bytes_queued < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 8) queue_random_frame();
            else queue_noise();
         end
         wait_idle();
      end

      if (mismatch_count == 0 && expected_changes.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
